FILE: hw/rtl/piecewise_linear_map_lookup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear map lookup
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_MAP_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_MAP_LOOKUP_MACROS_SVH

// Same-cycle implication
`define PLML_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PLML_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/plml_pkg.sv
// ----------------------------------------------------------------------------
// plml_pkg
// Types and constants shared by the piecewise linear map lookup modules.
// ----------------------------------------------------------------------------
`default_nettype none

package plml_pkg;

    // Field widths
    localparam int SPEED_W = 18;
    localparam int PUMP_W  = 16;
    localparam int EIDX_W  = 6;
    localparam int PU_W    = 7;
    localparam int EXT_W   = 9;     // holds any table depth up to 256
    localparam int PROD_W  = SPEED_W + PUMP_W;

    // Table defaults
    localparam int            TABLE_DEPTH_DEF = 64;
    localparam logic [PU_W-1:0] PU_RESET      = 7'd50;

    // Serial divider: quotient is always below 2**PUMP_W
    localparam int DIV_STEPS = PUMP_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // APB port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_POINTS_USED = 1'b0;

    // Item actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic write;     // store a breakpoint
        logic load;      // start a lookup
        logic scan;      // walk the table
        logic prep;      // form span, offset, delta
        logic mul;       // delta * offset
        logic div;       // one divider step
        logic out_load;  // post result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;       // upper point found
        logic scan_end;  // table exhausted without upper point
        logic div_last;  // final divider step
    } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/plml_ram.sv
// ----------------------------------------------------------------------------
// plml_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module plml_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/plml_dp.sv
// ----------------------------------------------------------------------------
// plml_dp
// Datapath: breakpoint memory, table scan, multiplier and serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_linear_map_lookup_macros.svh"

module plml_dp
    import plml_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic [PU_W-1:0]    points_used,
    input  wire logic [EIDX_W-1:0]  s_entry_index,
    input  wire logic [SPEED_W-1:0] s_point_speed,
    input  wire logic [PUMP_W-1:0]  s_point_pump,
    input  wire logic [SPEED_W-1:0] s_speed,
    output logic      [PUMP_W-1:0]  m_pump_target,
    output logic                    m_above_table
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Scan state
    logic [SPEED_W-1:0] speed_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               rvalid_reg;
    logic [SPEED_W-1:0] lo_s_reg;
    logic [PUMP_W-1:0]  lo_p_reg;
    logic [SPEED_W-1:0] hi_s_reg;
    logic [PUMP_W-1:0]  hi_p_reg;
    logic               above_reg;

    // Arithmetic state
    logic [SPEED_W-1:0] off_reg;
    logic [SPEED_W-1:0] span_reg;
    logic [PUMP_W-1:0]  delta_reg;
    logic               neg_reg;
    logic [SPEED_W-1:0] rem_reg;
    logic [PUMP_W-1:0]  quo_reg;
    logic [STEP_W-1:0]  step_reg;

    // Result
    logic [PUMP_W-1:0]  pump_out_reg;
    logic               above_out_reg;

    logic [EXT_W-1:0]          widx;
    logic [EXT_W-1:0]          pu_ext;
    logic [CNT_W-1:0]          n_next;
    logic                      we;
    logic                      issue;
    logic [PROD_W-1:0]         rdata;
    logic [SPEED_W-1:0]        ram_s;
    logic [PUMP_W-1:0]         ram_p;
    logic [PROD_W-1:0]         prod;
    logic [SPEED_W:0]          trial;
    logic                      ge;
    logic [PUMP_W-1:0]         interp;

    // Write decode: slots past the table are dropped
    assign widx = {{(EXT_W-EIDX_W){1'b0}}, s_entry_index};
    assign we   = cmd.write && (widx < EXT_W'(TABLE_DEPTH));

    // Scanned point count clamped to 1..TABLE_DEPTH
    assign pu_ext = {{(EXT_W-PU_W){1'b0}}, points_used};
    always_comb begin
        priority if (points_used == '0) begin
            n_next = CNT_W'(1);
        end else if (pu_ext > EXT_W'(TABLE_DEPTH)) begin
            n_next = CNT_W'(TABLE_DEPTH);
        end else begin
            n_next = pu_ext[CNT_W-1:0];
        end
    end

    plml_ram #(
        .DATA_W (PROD_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (widx[ADDR_W-1:0]),
        .wdata ({s_point_speed, s_point_pump}),
        .re    (issue),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign ram_s = rdata[PROD_W-1:PUMP_W];
    assign ram_p = rdata[PUMP_W-1:0];

    // Scan status; a read is issued every cycle until a hit or the end
    assign sts.hit      = rvalid_reg && (speed_reg < ram_s);
    assign sts.scan_end = !rvalid_reg && (rd_idx_reg == n_reg);
    assign sts.div_last = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign issue        = cmd.scan && (rd_idx_reg < n_reg) && !sts.hit;

    // Multiplier and divider step
    assign prod  = PROD_W'(delta_reg) * PROD_W'(off_reg);
    assign trial = {rem_reg, quo_reg[PUMP_W-1]};
    assign ge    = (trial >= {1'b0, span_reg});

    assign interp = neg_reg ? (lo_p_reg - quo_reg) : (lo_p_reg + quo_reg);

    // Control-like scan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            n_reg      <= CNT_W'(1);
            rvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            rd_idx_reg <= '0;
            n_reg      <= n_next;
            rvalid_reg <= 1'b0;
        end else if (cmd.scan) begin
            rvalid_reg <= issue;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            speed_reg <= s_speed;
            lo_s_reg  <= '0;
            lo_p_reg  <= '0;
            above_reg <= 1'b0;
        end
        if (cmd.scan) begin
            if (sts.hit) begin
                hi_s_reg <= ram_s;
                hi_p_reg <= ram_p;
            end else if (rvalid_reg) begin
                lo_s_reg <= ram_s;
                lo_p_reg <= ram_p;
            end
            if (sts.scan_end) begin
                above_reg <= 1'b1;
            end
        end
        if (cmd.prep) begin
            off_reg   <= speed_reg - lo_s_reg;
            span_reg  <= hi_s_reg - lo_s_reg;
            neg_reg   <= (hi_p_reg < lo_p_reg);
            delta_reg <= (hi_p_reg < lo_p_reg) ? (lo_p_reg - hi_p_reg)
                                               : (hi_p_reg - lo_p_reg);
        end
        if (cmd.mul) begin
            rem_reg  <= prod[PROD_W-1:PUMP_W];
            quo_reg  <= prod[PUMP_W-1:0];
            step_reg <= '0;
        end
        if (cmd.div) begin
            rem_reg  <= ge ? SPEED_W'(trial - {1'b0, span_reg}) : trial[SPEED_W-1:0];
            quo_reg  <= {quo_reg[PUMP_W-2:0], ge};
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.out_load) begin
            pump_out_reg  <= above_reg ? lo_p_reg : interp;
            above_out_reg <= above_reg;
        end
    end

    assign m_pump_target = pump_out_reg;
    assign m_above_table = above_out_reg;

    `PLML_ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1, (n_reg != '0) && (n_reg <= CNT_W'(TABLE_DEPTH)) && (rd_idx_reg <= n_reg), "scan count out of range")
    `PLML_ASSERT_IMPL(a_rem_below_span, aclk, aresetn, cmd.div, rem_reg < span_reg, "divider remainder not below span")

endmodule

`default_nettype wire

FILE: hw/rtl/plml_ctrl.sv
// ----------------------------------------------------------------------------
// plml_ctrl
// Controller: handshakes and sequencing of scan, multiply and divide.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_linear_map_lookup_macros.svh"

module plml_ctrl
    import plml_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_action,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   in_xfer;

    assign in_xfer = s_valid && s_ready;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_xfer) begin
                    if (s_action == ACT_LOOKUP) begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                priority if (sts.hit) begin
                    state_next = ST_PREP;
                end else if (sts.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register holds until its transfer
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `PLML_ASSERT_NEXT(a_lookup_scans, aclk, aresetn, cmd.load, state_reg == ST_SCAN, "lookup did not start a scan")
    `PLML_ASSERT_NEXT(a_result_posted, aclk, aresetn, cmd.out_load, m_valid_reg && (state_reg == ST_IDLE), "result not posted")
    `PLML_ASSERT_NEXT(a_div_finishes, aclk, aresetn, (state_reg == ST_DIV) && sts.div_last, state_reg == ST_DONE, "divider did not finish")

endmodule

`default_nettype wire

FILE: hw/rtl/piecewise_linear_map_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_map_lookup
// Speed to pump target map by linear interpolation over a breakpoint table.
// ----------------------------------------------------------------------------
// A write item (action 0) stores one (speed, pump) breakpoint; slots at or
// past TABLE_DEPTH are dropped. A lookup item (action 1) scans the first
// points_used breakpoints in order through the single read port of the table
// memory, one point per cycle, then runs one multiply and a 16-step serial
// divider, one quotient bit per cycle. A lookup that runs past the last of n
// points returns the last pump value with above_table set. Items are taken
// one at a time; a finished result waits in an output register while the
// next item is taken. The table has no reset and must be loaded before it is
// scanned. points_used resets to 50 and is written at byte address 0 of the
// APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_map_lookup
    import plml_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic [EIDX_W-1:0]  s_entry_index,
    input  wire logic [SPEED_W-1:0] s_point_speed,
    input  wire logic [PUMP_W-1:0]  s_point_pump,
    input  wire logic [SPEED_W-1:0] s_speed,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [PUMP_W-1:0]  m_pump_target,
    output logic                    m_above_table
);

    logic [PU_W-1:0] points_used_reg;
    logic            reg_sel;
    cmd_t            cmd;
    sts_t            sts;

    // Register decode on the word address
    assign reg_sel = (paddr[APB_AW-1:2] == REG_POINTS_USED);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(APB_DW-PU_W){1'b0}}, points_used_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_used_reg <= PU_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            points_used_reg <= pwdata[PU_W-1:0];
        end
    end

    plml_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    plml_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .points_used   (points_used_reg),
        .s_entry_index (s_entry_index),
        .s_point_speed (s_point_speed),
        .s_point_pump  (s_point_pump),
        .s_speed       (s_speed),
        .m_pump_target (m_pump_target),
        .m_above_table (m_above_table)
    );

endmodule

`default_nettype wire

FILE: tb/tb_piecewise_linear_map_lookup.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_map_lookup
// Self-checking bench for the speed to pump breakpoint map.
// ----------------------------------------------------------------------------
// Loads the breakpoint table, then runs directed lookups (below the first
// point, exact hits, rising and falling segments, beyond the last point) and
// the points_used limits, then random rounds with spread, dense and scrambled
// tables. A predictor kept in the bench tracks the table and points_used and
// queues the expected target of every accepted lookup; the monitor compares
// each result transfer against the oldest queued target. Both channels stall
// at random, and points_used is only rewritten while the block is idle.
// ----------------------------------------------------------------------------

module tb_piecewise_linear_map_lookup;
    import plml_pkg::*;

    localparam int CLK_PERIOD    = 8;
    // longest lookup: full 64-point scan plus multiply and divider
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_CYCLES    = 1_000_000;
    localparam int MAP_DEPTH     = TABLE_DEPTH_DEF;

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam logic [PUMP_W-1:0]  PUMP_MAX  = '1;
    localparam logic [APB_AW-1:0]  PU_ADDR   = APB_AW'(4 * int'(REG_POINTS_USED));

    typedef struct packed {
        logic [PUMP_W-1:0] pump;
        logic              above;
    } pump_target_t;

    typedef enum int {
        SHAPE_SPREAD,
        SHAPE_DENSE,
        SHAPE_SCRAMBLED
    } map_shape_t;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn;

    // configuration port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // input channel
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic [EIDX_W-1:0]  s_entry_index;
    logic [SPEED_W-1:0] s_point_speed;
    logic [PUMP_W-1:0]  s_point_pump;
    logic [SPEED_W-1:0] s_speed;

    // result channel
    logic              m_valid;
    logic              m_ready;
    logic [PUMP_W-1:0] m_pump_target;
    logic              m_above_table;

    // predictor state
    logic [SPEED_W-1:0] map_speed_pt [MAP_DEPTH];
    logic [PUMP_W-1:0]  map_pump_pt  [MAP_DEPTH];
    logic [PU_W-1:0]    cfg_points_used;

    pump_target_t pending_targets[$];
    pump_target_t due_target;
    int           mismatch_count;
    bit           gaps_enabled;

    piecewise_linear_map_lookup DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_entry_index (s_entry_index),
        .s_point_speed (s_point_speed),
        .s_point_pump  (s_point_pump),
        .s_speed       (s_speed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pump_target (m_pump_target),
        .m_above_table (m_above_table)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // points_used as the scan sees it: 0 acts as 1, clamp to table depth
    function automatic int effective_points(input logic [PU_W-1:0] pu);
        if (pu == 0)
            return 1;
        if (int'(pu) > MAP_DEPTH)
            return MAP_DEPTH;
        return int'(pu);
    endfunction

    function automatic pump_target_t map_speed_to_pump(input logic [SPEED_W-1:0] spd);
        int                 n;
        int                 i;
        bit                 has_upper;
        logic [SPEED_W-1:0] lo_s;
        logic [SPEED_W-1:0] hi_s;
        logic [PUMP_W-1:0]  lo_p;
        logic [PUMP_W-1:0]  hi_p;
        longint unsigned    span;
        longint unsigned    offs;
        longint unsigned    delta;
        longint unsigned    quot;
        pump_target_t       res;
        lo_s      = '0;
        lo_p      = '0;
        hi_s      = '0;
        hi_p      = '0;
        has_upper = 1'b0;
        n         = effective_points(cfg_points_used);
        i         = 0;
        // walk until the first point above the speed
        while (i < n && !has_upper) begin
            if (spd >= map_speed_pt[i]) begin
                lo_s = map_speed_pt[i];
                lo_p = map_pump_pt[i];
            end else begin
                hi_s      = map_speed_pt[i];
                hi_p      = map_pump_pt[i];
                has_upper = 1'b1;
            end
            i++;
        end
        res.above = !has_upper;
        res.pump  = lo_p;
        // interpolate; a zero span keeps the lower pump value
        if (has_upper && hi_s > lo_s && spd >= lo_s) begin
            span = 64'(hi_s) - 64'(lo_s);
            offs = 64'(spd) - 64'(lo_s);
            if (hi_p >= lo_p) begin
                delta    = 64'(hi_p) - 64'(lo_p);
                quot     = (delta * offs) / span;
                res.pump = PUMP_W'(64'(lo_p) + quot);
            end else begin
                delta    = 64'(lo_p) - 64'(hi_p);
                quot     = (delta * offs) / span;
                res.pump = PUMP_W'(64'(lo_p) - quot);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // drive one item and hold it until the transfer, then update the predictor
    task automatic send_transfer(input logic act, input logic [EIDX_W-1:0] idx,
                                 input logic [SPEED_W-1:0] pt_speed,
                                 input logic [PUMP_W-1:0] pt_pump,
                                 input logic [SPEED_W-1:0] spd);
        int unsigned gap;
        gap = gaps_enabled ? $urandom_range(0, 10) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_entry_index <= idx;
        s_point_speed <= pt_speed;
        s_point_pump  <= pt_pump;
        s_speed       <= spd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (act == ACT_WRITE) begin
            map_speed_pt[idx] = pt_speed;
            map_pump_pt[idx]  = pt_pump;
        end else begin
            pending_targets.push_back(map_speed_to_pump(spd));
        end
    endtask

    task automatic store_point(input logic [EIDX_W-1:0] idx,
                               input logic [SPEED_W-1:0] pt_speed,
                               input logic [PUMP_W-1:0] pt_pump);
        send_transfer(ACT_WRITE, idx, pt_speed, pt_pump, SPEED_W'($urandom));
    endtask

    task automatic lookup(input logic [SPEED_W-1:0] spd);
        send_transfer(ACT_LOOKUP, EIDX_W'($urandom), SPEED_W'($urandom),
                      PUMP_W'($urandom), spd);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_targets.size() != 0) @(posedge aclk);
    endtask

    // idle: no target outstanding and any trailing write has retired
    task automatic wait_idle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_points_used(input logic [PU_W-1:0] pu);
        wait_idle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PU_ADDR;
        pwdata  <= {{(APB_DW - PU_W){1'b0}}, pu};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cfg_points_used = pu;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // random stall before each result transfer
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        forever begin
            stall = gaps_enabled ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready && aresetn));
            @(negedge aclk);
        end
    end

    // compare each result transfer with the oldest expected target
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_targets.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transfer: expected none, actual pump %0d above %0b",
                         $time, m_pump_target, m_above_table);
            end else begin
                due_target = pending_targets.pop_front();
                if (m_pump_target !== due_target.pump) begin
                    mismatch_count++;
                    $display("%0t: pump_target mismatch: expected %0d, actual %0d",
                             $time, due_target.pump, m_pump_target);
                end
                if (m_above_table !== due_target.above) begin
                    mismatch_count++;
                    $display("%0t: above_table mismatch: expected %0b, actual %0b",
                             $time, due_target.above, m_above_table);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every slot gets written before any lookup scans it
    task automatic test_table_load();
        logic [SPEED_W-1:0] sp;
        logic [PUMP_W-1:0]  pp;
        for (int i = 0; i < MAP_DEPTH; i++) begin
            sp = (i == MAP_DEPTH - 1) ? SPEED_MAX : SPEED_W'(i * 4096 + 100);
            pp = (i % 2 == 0) ? PUMP_W'(i * 1000 + 3000) : PUMP_W'(65535 - i * 700);
            store_point(EIDX_W'(i), sp, pp);
        end
    endtask

    // points_used still at its reset value of 50
    task automatic test_lookup_directed();
        // below the first point: lower point is the origin
        lookup('0);
        lookup(SPEED_W'(99));
        // exact breakpoint hits
        lookup(SPEED_W'(100));
        lookup(SPEED_W'(4196));
        // rising segment, just below a point, falling segment
        lookup(SPEED_W'(2000));
        lookup(SPEED_W'(4195));
        lookup(SPEED_W'(4196 + 2048));
        // on the last scanned point and far beyond it
        lookup(SPEED_W'(49 * 4096 + 100));
        lookup(SPEED_MAX);
    endtask

    task automatic test_points_used_limits();
        // full table: last point sits at the top speed
        set_points_used(PU_W'(64));
        lookup(SPEED_MAX);
        lookup(SPEED_MAX - 1);
        // single point
        set_points_used(PU_W'(1));
        lookup(SPEED_W'(50));
        lookup(SPEED_W'(100));
        lookup(SPEED_W'(200));
        // zero scans one point
        set_points_used('0);
        lookup(SPEED_W'(50));
        lookup(SPEED_W'(200));
        // past the depth clamps to the full table
        set_points_used('1);
        lookup(SPEED_MAX - 1);
        set_points_used(PU_W'(65));
        lookup(SPEED_MAX - 1);
        lookup(SPEED_W'(10000));
    endtask

    // reload the scanned points, then mostly lookups near the breakpoints
    task automatic run_map_round(input logic [PU_W-1:0] pu, input map_shape_t shape,
                                 input int count, input bit no_gaps);
        int                 n;
        int                 step;
        int unsigned        sel;
        logic [SPEED_W-1:0] sp;
        logic [PUMP_W-1:0]  pp;
        logic [SPEED_W-1:0] base;
        set_points_used(pu);
        gaps_enabled = !no_gaps;
        n    = effective_points(pu);
        step = 262144 / n;
        sp   = SPEED_W'($urandom_range(0, 20));
        for (int i = 0; i < n; i++) begin
            case (shape)
                SHAPE_SPREAD:    sp = SPEED_W'(i * step + $urandom_range(0, step - 1));
                SHAPE_DENSE:     sp = (i == 0) ? sp : sp + SPEED_W'($urandom_range(0, 3));
                default:         sp = SPEED_W'($urandom);
            endcase
            sel = $urandom_range(0, 7);
            pp  = (sel == 0) ? '0 : (sel == 1) ? PUMP_MAX : PUMP_W'($urandom);
            store_point(EIDX_W'(i), sp, pp);
        end
        for (int k = 0; k < count; k++) begin
            // hold off once per round until all targets are back
            if (k == count / 2)
                wait_for_results();
            if ($urandom_range(0, 99) < 10) begin
                store_point(EIDX_W'($urandom), SPEED_W'($urandom), PUMP_W'($urandom));
            end else begin
                base = map_speed_pt[$urandom_range(0, n - 1)];
                sel  = $urandom_range(0, 9);
                if (sel < 3)
                    lookup(base);
                else if (sel < 5)
                    lookup(base - 1'b1);
                else if (sel < 7)
                    lookup(base + 1'b1);
                else if (sel < 9)
                    lookup(SPEED_W'($urandom));
                else
                    lookup($urandom_range(0, 1) ? SPEED_MAX : '0);
            end
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_maps();
        run_map_round(PU_W'(64), SHAPE_SPREAD, 55, 1'b0);
        run_map_round(PU_W'(1), SHAPE_SPREAD, 15, 1'b0);
        run_map_round(PU_W'($urandom_range(2, 63)), SHAPE_DENSE, 60, 1'b0);
        // back-to-back stretch with no stalls on either side
        run_map_round('1, SHAPE_SPREAD, 50, 1'b1);
        run_map_round('0, SHAPE_SCRAMBLED, 15, 1'b0);
        run_map_round(PU_W'($urandom_range(1, 64)), SHAPE_SCRAMBLED, 55, 1'b0);
        run_map_round(PU_W'($urandom_range(1, 64)), SHAPE_SPREAD, 75, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_action        = ACT_WRITE;
        s_entry_index   = '0;
        s_point_speed   = '0;
        s_point_pump    = '0;
        s_speed         = '0;
        gaps_enabled    = 1'b1;
        mismatch_count  = 0;
        cfg_points_used = PU_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_table_load();
        test_lookup_directed();
        test_points_used_limits();
        test_random_maps();

        wait_idle();
        if (mismatch_count == 0 && pending_targets.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #(CLK_PERIOD * MAX_CYCLES);
        $display("tb: failure");
        $finish;
    end

endmodule
